@@ rtl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Barometric compensation package
// Widths, calibration register indexes, fixed constants and the calibration
// word bundle shared by the compensation core and its submodules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

	localparam int CAL_W  = 16;
	localparam int ADC_W  = 24;
	localparam int TEMP_W = 19;
	localparam int PRES_W = 26;
	localparam int IDX_W  = 3;
	localparam int MUL_W  = 28;
	localparam int PROD_W = 2 * MUL_W;

	typedef enum logic [IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} cal_t;

	localparam logic [TEMP_W-1:0] TEMP_REF  = 19'd2000;
	localparam logic [TEMP_W-1:0] TEMP_COLD = 19'd1500;

	localparam logic [MUL_W-1:0] K_OFF_A  = 28'd61;
	localparam logic [MUL_W-1:0] K_SENS_A = 28'd29;
	localparam logic [MUL_W-1:0] K_OFF_B  = 28'd17;
	localparam logic [MUL_W-1:0] K_SENS_B = 28'd9;

	localparam logic [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};
	localparam logic [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};

endpackage

`default_nettype wire

@@ rtl/bpc_cfg.sv @@
// ----------------------------------------------------------------------------
// Calibration register file
// Holds the six calibration words. Writes to indexes beyond the list are
// dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [bpc_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [bpc_pkg::CAL_W-1:0]   cfg_data,
	output bpc_pkg::cal_t                    cal
);

	bpc_pkg::cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::REG_C1: begin
					cal_q.c1 <= cfg_data;
				end
				bpc_pkg::REG_C2: begin
					cal_q.c2 <= cfg_data;
				end
				bpc_pkg::REG_C3: begin
					cal_q.c3 <= cfg_data;
				end
				bpc_pkg::REG_C4: begin
					cal_q.c4 <= cfg_data;
				end
				bpc_pkg::REG_C5: begin
					cal_q.c5 <= cfg_data;
				end
				bpc_pkg::REG_C6: begin
					cal_q.c6 <= cfg_data;
				end
				default: begin
					cal_q <= cal_q;
				end
			endcase
		end
	end

	assign cal = cal_q;

endmodule

`default_nettype wire

@@ rtl/bpc_mul.sv @@
// ----------------------------------------------------------------------------
// Shared signed multiplier
// Two's complement multiply with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpc_mul (
	input  wire logic                         clk,
	input  wire logic [bpc_pkg::MUL_W-1:0]    op_a,
	input  wire logic [bpc_pkg::MUL_W-1:0]    op_b,
	output logic      [bpc_pkg::PROD_W-1:0]   prod
);

	logic [bpc_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= $signed(op_a) * $signed(op_b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

@@ rtl/barometric_pressure_compensation_core.sv @@
// ----------------------------------------------------------------------------
// Barometric pressure compensation core
// A temperature request is stored at acceptance and yields no result.
// A pressure request passes through fourteen products on the one shared
// 28 x 28 multiplier, two accumulate steps, then the output register, before
// its result is valid. Input ready is low meanwhile, so no further request
// is taken until the result is registered, and longer while an earlier
// result waits to be taken. Reset clears calibration words, stored reading
// and phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module barometric_pressure_compensation_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bpc_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [bpc_pkg::CAL_W-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [bpc_pkg::ADC_W-1:0]    adc_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [bpc_pkg::TEMP_W-1:0]   temperature_centi,
	output logic      [bpc_pkg::PRES_W-1:0]   pressure_centi
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DT_C6,
		ST_DT_SQ,
		ST_T2,
		ST_SENS1,
		ST_OFF1,
		ST_SENS_KA,
		ST_OFF_KA,
		ST_SENS_A2,
		ST_OFF_A2,
		ST_SENS_KB,
		ST_OFF_KB,
		ST_SENS_B2,
		ST_OFF_B2,
		ST_PLO,
		ST_PHI,
		ST_PSUB,
		ST_OUT
	} state_t;

	state_t state_q;

	bpc_pkg::cal_t cal;

	logic [bpc_pkg::MUL_W-1:0]  mul_a;
	logic [bpc_pkg::MUL_W-1:0]  mul_b;
	logic [bpc_pkg::PROD_W-1:0] prod;

	logic                         expect_q;
	logic [bpc_pkg::ADC_W-1:0]    traw_q;
	logic [bpc_pkg::ADC_W-1:0]    d1_q;
	logic [24:0]                  dt_q;
	logic [bpc_pkg::TEMP_W-1:0]   temp_q;
	logic [17:0]                  t2_q;
	logic [19:0]                  a_q;
	logic [19:0]                  b_q;
	logic [26:0]                  m_q;
	logic [26:0]                  m2_q;
	logic [39:0]                  sens_q;
	logic [43:0]                  off_q;
	logic [63:0]                  acc_q;
	logic [44:0]                  p_q;
	logic                         out_valid_q;
	logic [bpc_pkg::TEMP_W-1:0]   temperature_q;
	logic [bpc_pkg::PRES_W-1:0]   pressure_q;

	logic [24:0] dt_w;
	logic [19:0] a_w;
	logic [50:0] sq3_w;
	logic [51:0] sq5_w;
	logic [29:0] pf_w;
	logic [bpc_pkg::PRES_W-1:0] pres_w;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	bpc_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	always_comb begin
		dt_w  = {1'b0, traw_q} - {1'b0, cal.c5, 8'b0};
		a_w   = {temp_q[18], temp_q} - {1'b0, bpc_pkg::TEMP_REF};
		sq3_w = {2'b0, prod[48:0]} + {1'b0, prod[48:0], 1'b0};
		sq5_w = {3'b0, prod[48:0]} + {1'b0, prod[48:0], 2'b0};
		pf_w  = p_q[44:15];
		if (pf_w[29:25] == {5{pf_w[29]}}) begin
			pres_w = pf_w[25:0];
		end else if (pf_w[29]) begin
			pres_w = bpc_pkg::PRES_MIN;
		end else begin
			pres_w = bpc_pkg::PRES_MAX;
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DT_C6: begin
				mul_a = {{3{dt_q[24]}}, dt_q};
				mul_b = {12'b0, cal.c6};
			end
			ST_DT_SQ: begin
				mul_a = {{3{dt_q[24]}}, dt_q};
				mul_b = {{3{dt_q[24]}}, dt_q};
			end
			ST_T2: begin
				mul_a = {{3{dt_q[24]}}, dt_q};
				mul_b = {12'b0, cal.c3};
			end
			ST_SENS1: begin
				mul_a = {{3{dt_q[24]}}, dt_q};
				mul_b = {12'b0, cal.c4};
			end
			ST_OFF1: begin
				mul_a = {{8{a_q[19]}}, a_q};
				mul_b = bpc_pkg::K_SENS_A;
			end
			ST_SENS_KA: begin
				mul_a = {{8{a_q[19]}}, a_q};
				mul_b = bpc_pkg::K_OFF_A;
			end
			ST_OFF_KA: begin
				mul_a = {m_q[26], m_q};
				mul_b = {{8{a_q[19]}}, a_q};
			end
			ST_SENS_A2: begin
				mul_a = {m2_q[26], m2_q};
				mul_b = {{8{a_q[19]}}, a_q};
			end
			ST_OFF_A2: begin
				mul_a = {{8{b_q[19]}}, b_q};
				mul_b = bpc_pkg::K_SENS_B;
			end
			ST_SENS_KB: begin
				mul_a = {{8{b_q[19]}}, b_q};
				mul_b = bpc_pkg::K_OFF_B;
			end
			ST_OFF_KB: begin
				mul_a = {m_q[26], m_q};
				mul_b = {{8{b_q[19]}}, b_q};
			end
			ST_SENS_B2: begin
				mul_a = {m2_q[26], m2_q};
				mul_b = {{8{b_q[19]}}, b_q};
			end
			ST_OFF_B2: begin
				mul_a = {4'b0, d1_q};
				mul_b = {8'b0, sens_q[19:0]};
			end
			ST_PLO: begin
				mul_a = {4'b0, d1_q};
				mul_b = {{8{sens_q[39]}}, sens_q[39:20]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			expect_q      <= 1'b0;
			traw_q        <= '0;
			d1_q          <= '0;
			dt_q          <= '0;
			temp_q        <= '0;
			t2_q          <= '0;
			a_q           <= '0;
			b_q           <= '0;
			m_q           <= '0;
			m2_q          <= '0;
			sens_q        <= '0;
			off_q         <= '0;
			acc_q         <= '0;
			p_q           <= '0;
			out_valid_q   <= 1'b0;
			temperature_q <= '0;
			pressure_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (!expect_q) begin
							traw_q   <= adc_value;
							expect_q <= 1'b1;
						end else begin
							expect_q <= 1'b0;
							d1_q     <= adc_value;
							dt_q     <= dt_w;
							state_q  <= ST_DT_C6;
						end
					end
				end
				ST_DT_C6: begin
					state_q <= ST_DT_SQ;
				end
				ST_DT_SQ: begin
					temp_q  <= prod[41:23] + bpc_pkg::TEMP_REF;
					state_q <= ST_T2;
				end
				ST_T2: begin
					t2_q    <= a_w[19] ? sq3_w[50:33] : {4'b0, sq5_w[51:38]};
					a_q     <= a_w;
					b_q     <= {temp_q[18], temp_q} + {1'b0, bpc_pkg::TEMP_COLD};
					state_q <= ST_SENS1;
				end
				ST_SENS1: begin
					sens_q  <= {9'b0, cal.c1, 15'b0} + {{6{prod[41]}}, prod[41:8]};
					state_q <= ST_OFF1;
				end
				ST_OFF1: begin
					off_q   <= {12'b0, cal.c2, 16'b0} + {{9{prod[41]}}, prod[41:7]};
					state_q <= ST_SENS_KA;
				end
				ST_SENS_KA: begin
					m_q     <= prod[26:0];
					state_q <= ST_OFF_KA;
				end
				ST_OFF_KA: begin
					m2_q    <= prod[26:0];
					state_q <= ST_SENS_A2;
				end
				ST_SENS_A2: begin
					sens_q  <= sens_q - ({40{a_q[19]}} & {4'b0, prod[39:4]});
					state_q <= ST_OFF_A2;
				end
				ST_OFF_A2: begin
					off_q   <= off_q - ({44{a_q[19]}} & {4'b0, prod[43:4]});
					state_q <= ST_SENS_KB;
				end
				ST_SENS_KB: begin
					m_q     <= prod[26:0];
					state_q <= ST_OFF_KB;
				end
				ST_OFF_KB: begin
					m2_q    <= prod[26:0];
					state_q <= ST_SENS_B2;
				end
				ST_SENS_B2: begin
					sens_q  <= sens_q - ({40{b_q[19]}} & prod[39:0]);
					state_q <= ST_OFF_B2;
				end
				ST_OFF_B2: begin
					off_q   <= off_q - ({44{b_q[19]}} & prod[43:0]);
					state_q <= ST_PLO;
				end
				ST_PLO: begin
					acc_q   <= {{8{prod[55]}}, prod};
					state_q <= ST_PHI;
				end
				ST_PHI: begin
					acc_q   <= acc_q + {prod[43:0], 20'b0};
					state_q <= ST_PSUB;
				end
				ST_PSUB: begin
					p_q     <= {{2{acc_q[63]}}, acc_q[63:21]} - {off_q[43], off_q};
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						temperature_q <= temp_q - {1'b0, t2_q};
						pressure_q    <= pres_w;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready          = (state_q == ST_IDLE);
	assign out_valid         = out_valid_q;
	assign temperature_centi = temperature_q;
	assign pressure_centi    = pressure_q;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Barometric pressure compensation core testbench
// Sends raw converter readings, alternating temperature and pressure, through
// the request channel and checks every compensated result against an in-bench
// integer predictor or a typed table result. A directed table covers reset
// values, field extremes, the band edges at 20.00 C and -15.00 C, clamping
// and unmapped register writes. Random phases follow, each with fresh
// calibration words and one of four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int SETTLE_CYCLES   = 24;
	localparam int TAIL_CYCLES     = 40;
	localparam int STALL_LIMIT     = 5000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 240;

	localparam int SEND_IDLE  [4] = '{0, 81, 0, 6};
	localparam int RECV_STALL [4] = '{0, 0, 81, 6};

	localparam longint WARM_LIMIT = 2000;
	localparam longint COLD_LIMIT = -1500;
	localparam longint PRES_FLOOR = -33554432;
	localparam longint PRES_CEIL  = 33554431;
	localparam longint TEMP_FLOOR = -262144;
	localparam longint TEMP_CEIL  = 262143;

	localparam logic [bpc_pkg::IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [bpc_pkg::IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef enum logic {
		ROW_CFG,
		ROW_ADC
	} row_kind_t;

	typedef enum int {
		CAL_TYPICAL,
		CAL_UNIFORM,
		CAL_EXTREME
	} cal_mode_t;

	typedef struct packed {
		logic [bpc_pkg::TEMP_W-1:0] temperature;
		logic [bpc_pkg::PRES_W-1:0] pressure;
	} reading_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [bpc_pkg::IDX_W-1:0] index;
		logic [bpc_pkg::ADC_W-1:0] value;
		logic                      typed;
		reading_t                  result;
	} stim_row_t;

	// Typed results hold only where the outcome is obvious: with C1, C3..C6 at
	// zero, dT scales nothing and a zero temperature reading gives 20.00 C.
	localparam stim_row_t STIM_TABLE [44] = '{
		'{ROW_ADC, '0, 24'd0, 1'b0, '0},
		'{ROW_ADC, '0, 24'd0, 1'b1, '{19'd2000, 26'd0}},
		'{ROW_ADC, '0, 24'd0, 1'b0, '0},
		'{ROW_ADC, '0, 24'hFFFFFF, 1'b1, '{19'd2000, 26'd0}},
		'{ROW_CFG, bpc_pkg::REG_C2, 24'd1, 1'b0, '0},
		'{ROW_ADC, '0, 24'd0, 1'b0, '0},
		'{ROW_ADC, '0, 24'h5A5A5A, 1'b1, '{19'd2000, -26'sd2}},
		'{ROW_CFG, bpc_pkg::REG_C1, 24'd40127, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C2, 24'd36924, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C3, 24'd23317, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C4, 24'd23282, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C5, 24'd33464, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C6, 24'd28312, 1'b0, '0},
		'{ROW_ADC, '0, 24'd8569150, 1'b0, '0},
		'{ROW_ADC, '0, 24'd9085466, 1'b0, '0},
		'{ROW_ADC, '0, 24'd8000000, 1'b0, '0},
		'{ROW_ADC, '0, 24'd9085466, 1'b0, '0},
		'{ROW_ADC, '0, 24'd7000000, 1'b0, '0},
		'{ROW_ADC, '0, 24'hFFFFFF, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C5, 24'd3500, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C6, 24'd32768, 1'b0, '0},
		'{ROW_ADC, '0, 24'd0, 1'b0, '0},
		'{ROW_ADC, '0, 24'd9085466, 1'b0, '0},
		'{ROW_ADC, '0, 24'd895999, 1'b0, '0},
		'{ROW_ADC, '0, 24'd4000000, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C1, 24'd65535, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C2, 24'd65535, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C3, 24'd65535, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C4, 24'd65535, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C5, 24'd65535, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C6, 24'd65535, 1'b0, '0},
		'{ROW_ADC, '0, 24'd0, 1'b0, '0},
		'{ROW_ADC, '0, 24'hFFFFFF, 1'b0, '0},
		'{ROW_ADC, '0, 24'hFFFFFF, 1'b0, '0},
		'{ROW_ADC, '0, 24'd0, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C1, 24'd0, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C2, 24'd0, 1'b0, '0},
		'{ROW_CFG, bpc_pkg::REG_C4, 24'd0, 1'b0, '0},
		'{ROW_ADC, '0, 24'd0, 1'b0, '0},
		'{ROW_ADC, '0, 24'hFFFFFF, 1'b0, '0},
		'{ROW_CFG, IDX_SPARE_LO, 24'h001234, 1'b0, '0},
		'{ROW_CFG, IDX_SPARE_HI, 24'h00FFFF, 1'b0, '0},
		'{ROW_ADC, '0, 24'h800000, 1'b0, '0},
		'{ROW_ADC, '0, 24'h7FFFFF, 1'b0, '0}
	};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [bpc_pkg::IDX_W-1:0]    cfg_index = '0;
	logic [bpc_pkg::CAL_W-1:0]    cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [bpc_pkg::ADC_W-1:0]    adc_value = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [bpc_pkg::TEMP_W-1:0]   temperature_centi;
	logic [bpc_pkg::PRES_W-1:0]   pressure_centi;

	bpc_pkg::cal_t              cal_shadow = '0;
	logic [bpc_pkg::ADC_W-1:0]  held_temperature = '0;
	logic                       awaiting_pressure = 1'b0;
	reading_t                   expected_readings[$];
	int                         mismatches = 0;
	int                         send_idle_pct = 0;
	int                         recv_stall_pct = 0;

	barometric_pressure_compensation_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.adc_value         (adc_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.pressure_centi    (pressure_centi)
	);

	always #2 clk = ~clk;

	function automatic reading_t compensate_reading(
			input logic [bpc_pkg::ADC_W-1:0] pres_raw,
			input logic [bpc_pkg::ADC_W-1:0] temp_raw);
		longint c1, c2, c3, c4, c5, c6;
		longint dt, temp, t2, off2, sens2, off, sens, p, a, b, t_out;
		reading_t res;
		c1 = longint'(cal_shadow.c1);
		c2 = longint'(cal_shadow.c2);
		c3 = longint'(cal_shadow.c3);
		c4 = longint'(cal_shadow.c4);
		c5 = longint'(cal_shadow.c5);
		c6 = longint'(cal_shadow.c6);
		dt = longint'(temp_raw) - c5 * 256;
		temp = WARM_LIMIT + ((dt * c6) >>> 23);
		if (temp < WARM_LIMIT) begin
			a = temp - WARM_LIMIT;
			t2 = (3 * dt * dt) >>> 33;
			off2 = 61 * a * a / 16;
			sens2 = 29 * a * a / 16;
			if (temp < COLD_LIMIT) begin
				b = temp - COLD_LIMIT;
				off2 += 17 * b * b;
				sens2 += 9 * b * b;
			end
		end else begin
			t2 = (5 * dt * dt) >>> 38;
			off2 = 0;
			sens2 = 0;
		end
		off = c2 * 65536 + ((c4 * dt) >>> 7) - off2;
		sens = c1 * 32768 + ((c3 * dt) >>> 8) - sens2;
		p = (((longint'(pres_raw) * sens) >>> 21) - off) >>> 15;
		if (p < PRES_FLOOR) p = PRES_FLOOR;
		if (p > PRES_CEIL) p = PRES_CEIL;
		t_out = temp - t2;
		if (t_out < TEMP_FLOOR) t_out = TEMP_FLOOR;
		if (t_out > TEMP_CEIL) t_out = TEMP_CEIL;
		res.temperature = t_out[bpc_pkg::TEMP_W-1:0];
		res.pressure = p[bpc_pkg::PRES_W-1:0];
		return res;
	endfunction

	function automatic logic [bpc_pkg::CAL_W-1:0] pick_cal_word(input cal_mode_t mode);
		case (mode)
			CAL_TYPICAL: return bpc_pkg::CAL_W'($urandom_range(49151, 16384));
			CAL_EXTREME: return $urandom_range(1) ? '1 : '0;
			default:     return bpc_pkg::CAL_W'($urandom_range(65535));
		endcase
	endfunction

	// Half of the temperature readings sit near the reference so that all three
	// temperature bands are reached; the rest span the whole field.
	function automatic logic [bpc_pkg::ADC_W-1:0] pick_temperature_raw();
		longint centre, v;
		int span;
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return bpc_pkg::ADC_W'($urandom);
			default: begin
				centre = longint'(cal_shadow.c5) * 256;
				span = 1 << $urandom_range(22);
				v = centre - span + longint'($urandom_range(2 * span));
				if (v < 0) v = 0;
				if (v > 24'hFFFFFF) v = 24'hFFFFFF;
				return v[bpc_pkg::ADC_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [bpc_pkg::ADC_W-1:0] pick_pressure_raw();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return bpc_pkg::ADC_W'($urandom);
		endcase
	endfunction

	task automatic write_cal(input logic [bpc_pkg::IDX_W-1:0] idx,
			input logic [bpc_pkg::CAL_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			bpc_pkg::REG_C1: cal_shadow.c1 = data;
			bpc_pkg::REG_C2: cal_shadow.c2 = data;
			bpc_pkg::REG_C3: cal_shadow.c3 = data;
			bpc_pkg::REG_C4: cal_shadow.c4 = data;
			bpc_pkg::REG_C5: cal_shadow.c5 = data;
			bpc_pkg::REG_C6: cal_shadow.c6 = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Valid stays high after an accepted request; the next call either
	// replaces the payload or drops valid for a gap.
	task automatic send_reading(input logic [bpc_pkg::ADC_W-1:0] raw, input logic typed,
			input reading_t typed_result);
		reading_t res;
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		adc_value <= raw;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (!awaiting_pressure) begin
			held_temperature = raw;
			awaiting_pressure = 1'b1;
		end else begin
			awaiting_pressure = 1'b0;
			res = compensate_reading(raw, held_temperature);
			expected_readings.push_back(typed ? typed_result : res);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	task automatic quiesce();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual T %0d P %0d", $time,
					$signed(temperature_centi), $signed(pressure_centi));
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				if (temperature_centi !== want.temperature) begin
					$display("%0t: temperature_centi expected %0d actual %0d", $time,
						$signed(want.temperature), $signed(temperature_centi));
					mismatches++;
				end
				if (pressure_centi !== want.pressure) begin
					$display("%0t: pressure_centi expected %0d actual %0d", $time,
						$signed(want.pressure), $signed(pressure_centi));
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int stale;
		stale = 0;
		while (stale < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				stale = 0;
			else
				stale++;
		end
		$display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		cal_mode_t mode;
		bpc_pkg::reg_idx_t idx;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (STIM_TABLE[i]) begin
			if (STIM_TABLE[i].kind == ROW_CFG) begin
				quiesce();
				write_cal(STIM_TABLE[i].index, STIM_TABLE[i].value[bpc_pkg::CAL_W-1:0]);
			end else begin
				send_reading(STIM_TABLE[i].value, STIM_TABLE[i].typed,
					STIM_TABLE[i].result);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			quiesce();
			mode = cal_mode_t'(phase % 3);
			idx = idx.first();
			repeat (idx.num()) begin
				write_cal(idx, pick_cal_word(mode));
				idx = idx.next();
			end
			write_cal($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO,
				bpc_pkg::CAL_W'($urandom_range(65535)));
			send_idle_pct = SEND_IDLE[phase % 4];
			recv_stall_pct = RECV_STALL[phase % 4];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(63) == 0)
					drain_results();
				send_reading(awaiting_pressure ? pick_pressure_raw() : pick_temperature_raw(),
					1'b0, '0);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
